// ===== design/assert_macros.svh =====
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define BCV_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent assertion on the block clock and reset
`define BCV_ASSERT(lbl, prop, msg) \
  `BCV_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== design/bcv_pkg.sv =====
`timescale 1ns / 1ps

package bcv_pkg;

  localparam int PortW    = 3;
  localparam int BtnW     = 32;
  localparam int CntW     = 32;
  localparam int TimeW    = 64;
  localparam int VolW     = 5;
  localparam int LevelW   = 7;
  localparam int CfgW     = 32;
  localparam int CfgIdxW  = 3;

  localparam int NumPortsDef = 4;

  localparam logic [VolW-1:0]   VolMax       = 5'd30;
  localparam logic [LevelW-1:0] LevelLowered = 7'd100;
  localparam logic [LevelW-1:0] BrightFull   = 7'd100;
  localparam logic [LevelW-1:0] BrightDim    = 7'd5;
  localparam logic [6:0]        CntMax       = 7'd64;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TV_MODE       = 3'd0,
    CFG_REPEAT_US     = 3'd1,
    CFG_BRIGHT_CHORD  = 3'd2,
    CFG_MUTE_CHORD    = 3'd3,
    CFG_DOWN_CHORD    = 3'd4,
    CFG_UP_CHORD      = 3'd5,
    CFG_VOL_DOWN_BIT  = 3'd6,
    CFG_VOL_UP_BIT    = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic            tv_mode;
    logic [CfgW-1:0] repeat_interval_us;
    logic [BtnW-1:0] brightness_chord;
    logic [BtnW-1:0] mute_chord;
    logic [BtnW-1:0] down_chord;
    logic [BtnW-1:0] up_chord;
    logic [BtnW-1:0] vol_down_bit;
    logic [BtnW-1:0] vol_up_bit;
  } cfg_t;

  // input item, laid out as on tdata (last field lowest)
  typedef struct packed {
    logic [VolW-1:0]         current_volume;
    logic [TimeW-1:0]        now_us;
    logic signed [CntW-1:0]  read_result;
    logic [BtnW-1:0]         buttons_in;
    logic [PortW-1:0]        port_number;
  } in_item_t;

  // result item, laid out as on tdata with byte padding on top
  typedef struct packed {
    logic [2:0]        pad;
    logic [LevelW-1:0] brightness_percent;
    logic [VolW-1:0]   new_volume;
    logic              volume_write;
    logic [BtnW-1:0]   buttons_out;
  } out_item_t;

endpackage

// ===== design/button_chord_volume_control_top.sv =====
`timescale 1ns / 1ps

// Button chord volume control: each item is one controller sample, and each
// sample yields exactly one result item, loaded from the sample in the input
// register. Samples whose read count lies outside 1..64 pass unchanged. An exact
// four-shoulder chord toggles that port's lightbar brightness between 100 and 5
// percent once per press; in handheld mode the volume chords are rewritten to
// volume button bits, and in tv mode they mute, step the master volume (0..30,
// rate limited by repeat_interval_us) or restore it, with the buttons cleared.
// Throughput is one item per clock while the result side is not stalled: the
// input register feeds a single pass of compare and increment logic that
// updates the chord state and loads the result register in the same cycle, so
// the next item already sees the new state. An accepted item is held in the
// input register and then in the result register; a stalled result side holds
// both registers and backs up the input ready. Configuration registers are to be
// written by the user only while no item is in flight; the block does not enforce it.

`include "assert_macros.svh"

module button_chord_volume_control_top #(
  parameter int NUM_PORTS = bcv_pkg::NumPortsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic [bcv_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bcv_pkg::CfgW-1:0]    cfg_wdata_i,
  // sample items in
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // port_number[2:0], buttons_in[34:3], read_result[66:35], now_us[130:67],
  // current_volume[135:131]
  input  logic [135:0]                s_axis_tdata_i,
  // result items out
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // buttons_out[31:0], volume_write[32], new_volume[37:33],
  // brightness_percent[44:38], zero[47:45]
  output logic [47:0]                 m_axis_tdata_o
);
  import bcv_pkg::*;

  cfg_t      cfg;
  in_item_t  in_item;
  in_item_t  held_item;
  logic      held_valid;
  logic      advance;
  logic      step;
  out_item_t result;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q;

  logic      stalled;
  logic      bright_ok;

  // result slot frees when empty or being drained this cycle
  assign advance = !out_valid_q || m_axis_tready_i;
  assign step    = held_valid && advance;
  assign in_item = in_item_t'(s_axis_tdata_i);

  bcv_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bcv_in_reg u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .ready_o   (s_axis_tready_o),
    .item_i    (in_item),
    .advance_i (advance),
    .valid_o   (held_valid),
    .item_o    (held_item)
  );

  bcv_core #(
    .NUM_PORTS (NUM_PORTS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (held_item),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  // both registers full and the sink not taking the result
  assign stalled   = held_valid && out_valid_q && !m_axis_tready_i;
  // full, dim or zero for a bad port
  assign bright_ok = (out_q.brightness_percent == BrightFull) ||
                     (out_q.brightness_percent == BrightDim) ||
                     (out_q.brightness_percent == 7'd0);

  // a held sample is never dropped while the result side is stalled
  `BCV_ASSERT(a_hold_in, stalled |=> held_valid, "sample lost under stall")

  // an empty input register always takes a new sample
  `BCV_ASSERT(a_ready_empty, !held_valid |-> s_axis_tready_o, "input register empty but not ready")

  // reported brightness is only ever full, dim or zero for a bad port
  `BCV_ASSERT(a_bright_val, m_axis_tvalid_o |-> bright_ok, "bad brightness")

endmodule

// ===== design/bcv_cfg_regs.sv =====
`timescale 1ns / 1ps

module bcv_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bcv_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bcv_pkg::CfgW-1:0]    cfg_wdata_i,
  output bcv_pkg::cfg_t               cfg_o
);
  import bcv_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_TV_MODE:      cfg_d.tv_mode            = cfg_wdata_i[0];
        CFG_REPEAT_US:    cfg_d.repeat_interval_us = cfg_wdata_i;
        CFG_BRIGHT_CHORD: cfg_d.brightness_chord   = cfg_wdata_i;
        CFG_MUTE_CHORD:   cfg_d.mute_chord         = cfg_wdata_i;
        CFG_DOWN_CHORD:   cfg_d.down_chord         = cfg_wdata_i;
        CFG_UP_CHORD:     cfg_d.up_chord           = cfg_wdata_i;
        CFG_VOL_DOWN_BIT: cfg_d.vol_down_bit       = cfg_wdata_i;
        CFG_VOL_UP_BIT:   cfg_d.vol_up_bit         = cfg_wdata_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tv_mode            <= 1'b1;
      cfg_q.repeat_interval_us <= 32'd100000;
      cfg_q.brightness_chord   <= 32'h0000_0F00;
      cfg_q.mute_chord         <= 32'h0000_0C01;
      cfg_q.down_chord         <= 32'h0000_0401;
      cfg_q.up_chord           <= 32'h0000_0801;
      cfg_q.vol_down_bit       <= 32'h0080_0000;
      cfg_q.vol_up_bit         <= 32'h0040_0000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/bcv_in_reg.sv =====
`timescale 1ns / 1ps

module bcv_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  bcv_pkg::in_item_t item_i,
  input  logic              advance_i,
  output logic              valid_o,
  output bcv_pkg::in_item_t item_o
);
  import bcv_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     take;

  // slot frees when the held item moves on this cycle
  assign ready_o = !valid_q || advance_i;
  assign take    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== design/bcv_core.sv =====
`timescale 1ns / 1ps

module bcv_core #(
  parameter int NUM_PORTS = bcv_pkg::NumPortsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  bcv_pkg::in_item_t  item_i,
  input  bcv_pkg::cfg_t      cfg_i,
  output bcv_pkg::out_item_t result_o
);
  import bcv_pkg::*;

  localparam int IdxW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  logic [LevelW-1:0] saved_q, saved_d;
  logic [TimeW-1:0]  last_q, last_d;
  logic              mute_q, mute_d;
  logic              toggle_q [NUM_PORTS];
  logic [LevelW-1:0] bright_q [NUM_PORTS];

  logic              pvalid;
  logic [PortW-1:0]  port_m1;
  logic [IdxW-1:0]   pi;
  logic              cnt_ok;
  logic [BtnW-1:0]   btn;
  logic [VolW-1:0]   vol;
  logic [TimeW-1:0]  elapsed;
  logic              interval_ok;
  logic              is_up;
  logic              tog_cur;
  logic [LevelW-1:0] bright_cur;
  logic              tog_we, tog_d;
  logic              bright_we;
  logic [LevelW-1:0] bright_d;
  logic [BtnW-1:0]   bout;
  logic              wr;
  logic [VolW-1:0]   nvol;

  assign btn     = item_i.buttons_in;
  assign vol     = item_i.current_volume;
  assign pvalid  = (item_i.port_number != '0) &&
                   ({1'b0, item_i.port_number} <= (PortW+1)'(NUM_PORTS));
  assign port_m1 = item_i.port_number - 3'd1;
  assign pi      = pvalid ? port_m1[IdxW-1:0] : '0;
  assign cnt_ok  = (item_i.read_result[31:7] == '0) &&
                   (item_i.read_result[6:0] != 7'd0) &&
                   (item_i.read_result[6:0] <= CntMax);

  assign elapsed     = item_i.now_us - last_q;
  assign interval_ok = elapsed > {32'd0, cfg_i.repeat_interval_us};
  assign is_up       = (btn != cfg_i.down_chord);

  assign tog_cur    = toggle_q[pi];
  assign bright_cur = bright_q[pi];

  always_comb begin
    saved_d   = saved_q;
    last_d    = last_q;
    mute_d    = mute_q;
    tog_we    = 1'b0;
    tog_d     = 1'b0;
    bright_we = 1'b0;
    bright_d  = bright_cur;
    bout      = btn;
    wr        = 1'b0;
    nvol      = vol;
    if (cnt_ok) begin
      if (btn == cfg_i.brightness_chord) begin
        if (pvalid && !tog_cur) begin
          tog_we    = 1'b1;
          tog_d     = 1'b1;
          bright_we = 1'b1;
          if (bright_cur == BrightFull) begin
            bright_d = BrightDim;
          end else if (bright_cur == BrightDim) begin
            bright_d = BrightFull;
          end
        end
      end else if (!cfg_i.tv_mode) begin
        if (btn == cfg_i.mute_chord) begin
          bout = cfg_i.vol_down_bit | cfg_i.vol_up_bit;
        end else if (btn == cfg_i.down_chord) begin
          bout = cfg_i.vol_down_bit;
        end else if (btn == cfg_i.up_chord) begin
          bout = cfg_i.vol_up_bit;
        end else if (btn == '0 && pvalid) begin
          tog_we = 1'b1;
        end
      end else if (btn == cfg_i.mute_chord) begin
        if (vol != '0) begin
          saved_d = {2'b00, vol};
        end
        wr     = 1'b1;
        nvol   = '0;
        mute_d = 1'b1;
        last_d = item_i.now_us;
        bout   = '0;
      end else if (btn == cfg_i.down_chord || btn == cfg_i.up_chord) begin
        if (!mute_q && interval_ok) begin
          if (!is_up) begin
            if (vol != '0) begin
              if (vol == 5'd1) begin
                saved_d = LevelLowered;
              end
              wr   = 1'b1;
              nvol = vol - 5'd1;
            end else if (saved_q != LevelLowered) begin
              wr   = 1'b1;
              nvol = saved_q[VolW-1:0];
            end
          end else begin
            if (vol >= VolMax) begin
              wr = 1'b0;
            end else if (vol != '0) begin
              wr   = 1'b1;
              nvol = vol + 5'd1;
            end else if (saved_q != LevelLowered) begin
              wr   = 1'b1;
              nvol = saved_q[VolW-1:0];
            end else begin
              wr   = 1'b1;
              nvol = 5'd1;
            end
          end
          last_d = item_i.now_us;
        end
        bout = '0;
      end else if (btn == '0) begin
        tog_we = pvalid;
        if (item_i.port_number == 3'd1) begin
          mute_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      saved_q <= LevelLowered;
      last_q  <= '0;
      mute_q  <= 1'b0;
      for (int i = 0; i < NUM_PORTS; i++) begin
        toggle_q[i] <= 1'b0;
        bright_q[i] <= BrightFull;
      end
    end else if (step_i) begin
      saved_q <= saved_d;
      last_q  <= last_d;
      mute_q  <= mute_d;
      if (tog_we) begin
        toggle_q[pi] <= tog_d;
      end
      if (bright_we) begin
        bright_q[pi] <= bright_d;
      end
    end
  end

  always_comb begin
    result_o                    = '0;
    result_o.buttons_out        = bout;
    result_o.volume_write       = wr;
    result_o.new_volume         = nvol;
    result_o.brightness_percent = pvalid ? bright_d : '0;
  end

endmodule
